FILE: rtl/core/drws_pkg.sv
// shared types, constants and helper functions of the random walk step block
package drws_pkg;

   localparam int GRID_SIDE_DEFAULT = 1024;
   localparam int COORD_W           = 10;
   localparam int COORD_MAX         = 1023;
   localparam int RADIUS_W          = 9;
   localparam int DIR_W             = 3;
   localparam int CSR_IDX_W         = 2;
   localparam int CSR_DATA_W        = 10;
   localparam int EXT_W             = COORD_W + 2;
   localparam int MAG_W             = 11;
   localparam int SQ_W              = 21;
   localparam int SUM_W             = 22;
   localparam int R2_W              = 2 * RADIUS_W;
   localparam int CNT_W             = 4;
   localparam int NB_COUNT          = 9;
   localparam int SQ_STEPS          = 6;
   localparam int RD_ROWS           = 3;

   localparam logic [COORD_W-1:0]  CENTER_RESET = 10'd511;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 9'd485;
   // every neighbour position of the 3x3 window except the walker itself
   localparam logic [NB_COUNT-1:0] NB_MASK      = 9'b111101111;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER = 2'd0,
      CSR_RADIUS = 2'd1
   } csr_index_type;

   typedef enum logic [DIR_W-1:0] {
      DIR_PX   = 3'd0,
      DIR_MX   = 3'd1,
      DIR_PY   = 3'd2,
      DIR_MY   = 3'd3,
      DIR_PXPY = 3'd4,
      DIR_MXMY = 3'd5,
      DIR_MXPY = 3'd6,
      DIR_PXMY = 3'd7
   } dir_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SQUARE,
      ST_COMPARE,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic             capture;
      logic             clr_en;
      logic             rd_en;
      logic [1:0]       rd_k;
      logic             sq_en;
      logic [2:0]       sq_idx;
      logic             cmp_en;
      logic [CNT_W-1:0] cmp_idx;
      logic             decide_en;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic done;
      logic out_busy;
   } status_type;

   typedef struct packed {
      logic signed [1:0] dx;
      logic signed [1:0] dy;
   } delta_type;

   typedef struct packed {
      logic [1:0] row;
      logic [1:0] col;
   } nb_pos_type;

   function automatic delta_type step_delta(logic [DIR_W-1:0] dir);
      delta_type d;
      case (dir_type'(dir))
         DIR_PX:   d = '{dx: 2'sd1,  dy: 2'sd0};
         DIR_MX:   d = '{dx: -2'sd1, dy: 2'sd0};
         DIR_PY:   d = '{dx: 2'sd0,  dy: 2'sd1};
         DIR_MY:   d = '{dx: 2'sd0,  dy: -2'sd1};
         DIR_PXPY: d = '{dx: 2'sd1,  dy: 2'sd1};
         DIR_MXMY: d = '{dx: -2'sd1, dy: -2'sd1};
         DIR_MXPY: d = '{dx: -2'sd1, dy: 2'sd1};
         DIR_PXMY: d = '{dx: 2'sd1,  dy: -2'sd1};
         default:  d = '{dx: 2'sd0,  dy: 2'sd0};
      endcase
      return d;
   endfunction

   // window position of a neighbour index, row major
   function automatic nb_pos_type nb_pos(logic [CNT_W-1:0] idx);
      nb_pos_type p;
      case (idx)
         4'd0:    p = '{row: 2'd0, col: 2'd0};
         4'd1:    p = '{row: 2'd0, col: 2'd1};
         4'd2:    p = '{row: 2'd0, col: 2'd2};
         4'd3:    p = '{row: 2'd1, col: 2'd0};
         4'd4:    p = '{row: 2'd1, col: 2'd1};
         4'd5:    p = '{row: 2'd1, col: 2'd2};
         4'd6:    p = '{row: 2'd2, col: 2'd0};
         4'd7:    p = '{row: 2'd2, col: 2'd1};
         4'd8:    p = '{row: 2'd2, col: 2'd2};
         default: p = '{row: 2'd1, col: 2'd1};
      endcase
      return p;
   endfunction

endpackage

FILE: rtl/core/dla_random_walk_step.sv
// top level of the diffusion-limited aggregation random walk step block
//
// One req transaction carries a direction and yields exactly one rsp transaction.
// A walking step runs from acceptance through the square, compare and decide
// states, and the decide state loads the result; the next transaction is taken
// only once the controller is back in idle. One shared 11x11 squarer works
// through the six axis offsets while the three neighbour rows are read from the
// single-port grid memory. Then the nine window positions are checked against
// the radius one per cycle, and the decide state updates the walker and grid.
// Once finished, a transaction goes from acceptance straight to the decide
// state, which loads its result. A result register lets the next transaction
// be accepted while a result still waits to be taken. The decide state waits
// for as long as that register still holds an untaken result. After reset the
// grid is cleared one row per cycle, all GRID_SIDE rows (1024 at the default
// size). No request is accepted during that time, while register writes are
// taken. Writing the center register also moves the walker to the new center.
module dla_random_walk_step import drws_pkg::*; #(
   parameter int GRID_SIDE = GRID_SIDE_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [DIR_W-1:0]      req_direction,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COORD_W-1:0]    rsp_walker_x,
   output logic [COORD_W-1:0]    rsp_walker_y,
   output logic                  rsp_deposited,
   output logic                  rsp_finished,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // registers accept every write, so csr_ready is tied high
   assign csr_ready = 1'b1;

   drws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   drws_datapath #(
      .GRID_SIDE (GRID_SIDE)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_direction (req_direction),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_walker_x  (rsp_walker_x),
      .rsp_walker_y  (rsp_walker_y),
      .rsp_deposited (rsp_deposited),
      .rsp_finished  (rsp_finished)
   );

endmodule

FILE: rtl/core/drws_ctrl.sv
// step sequencer: grid clearing, square/compare sweeps and the stick decision
module drws_ctrl import drws_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            cnt_in    = '0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               // once finished, a transaction only repeats the last result
               state_in = status.done ? ST_DECIDE : ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            // row reads overlap the first square steps
            cmd.sq_en  = (cnt_ff < CNT_W'(SQ_STEPS));
            cmd.sq_idx = cnt_ff[2:0];
            cmd.rd_en  = (cnt_ff < CNT_W'(RD_ROWS));
            cmd.rd_k   = cnt_ff[1:0];
            if (cnt_ff == CNT_W'(SQ_STEPS)) begin
               state_in = ST_COMPARE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_COMPARE: begin
            cmd.cmp_en  = 1'b1;
            cmd.cmp_idx = cnt_ff;
            if (cnt_ff == CNT_W'(NB_COUNT - 1)) begin
               state_in = ST_DECIDE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DECIDE: begin
            if (!status.out_busy) begin
               cmd.decide_en = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/core/drws_datapath.sv
// grid memory, walker and config registers, distance test and result register
module drws_datapath import drws_pkg::*; #(
   parameter int GRID_SIDE = GRID_SIDE_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [DIR_W-1:0]      req_direction,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic [COORD_W-1:0]    rsp_walker_x,
   output logic [COORD_W-1:0]    rsp_walker_y,
   output logic                  rsp_deposited,
   output logic                  rsp_finished
);

   localparam int IDX_W = $clog2(GRID_SIDE);

   function automatic logic [EXT_W-1:0] offset_coord(logic [COORD_W-1:0] c, logic [1:0] o);
      return {2'b00, c} + {{(EXT_W-2){1'b0}}, o} - EXT_W'(1);
   endfunction

   function automatic logic ext_ok(logic [EXT_W-1:0] e);
      return (e <= EXT_W'(COORD_MAX)) && ({1'b0, e} < (EXT_W+1)'(GRID_SIDE));
   endfunction

   // configuration and walker state
   logic [COORD_W-1:0]  center_ff;
   logic [RADIUS_W-1:0] radius_ff;
   logic [R2_W-1:0]     r2_ff;
   logic [COORD_W-1:0]  walk_x_ff, walk_x_in;
   logic [COORD_W-1:0]  walk_y_ff, walk_y_in;
   logic                done_ff, done_in;
   logic [DIR_W-1:0]    dir_ff;

   // grid memory and its read pipeline
   logic [GRID_SIDE-1:0] grid_mem [GRID_SIDE];
   logic [GRID_SIDE-1:0] rd_data_ff;
   logic [IDX_W-1:0]     clr_row_ff;
   logic                 rd_pend_ff;
   logic [1:0]           rd_k_ff;
   logic                 row_ok_ff;
   logic [NB_COUNT-1:0]  bits_ff;

   // distance test
   logic [MAG_W-1:0]     mag_ff;
   logic [2:0]           mag_idx_ff;
   logic                 mag_vld_ff;
   logic [SQ_W-1:0]      sqx_ff [3];
   logic [SQ_W-1:0]      sqy_ff [3];
   logic [NB_COUNT-1:0]  circ_ff;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0]   rsp_x_ff, rsp_x_in;
   logic [COORD_W-1:0]   rsp_y_ff, rsp_y_in;
   logic                 rsp_deposited_ff, rsp_deposited_in;
   logic                 rsp_finished_ff;

   logic [EXT_W-1:0]     col_ext [3];
   logic                 col_ok [3];
   logic [IDX_W-1:0]     col_idx [3];
   logic [EXT_W-1:0]     row_ext;
   logic [EXT_W-1:0]     wr_x_ext, wr_y_ext;
   logic [IDX_W-1:0]     wr_col, wr_row;
   logic                 wr_en;
   logic                 stick_off;
   logic                 touch;
   logic                 off_center;
   delta_type            delta;
   logic                 sq_is_x;
   logic [1:0]           sq_off;
   logic [COORD_W-1:0]   sq_coord;
   logic [EXT_W-1:0]     sq_ext;
   logic [EXT_W:0]       sq_diff, sq_abs;
   logic [2*MAG_W-1:0]   sq_prod;
   nb_pos_type           cmp_pos;
   logic [SUM_W-1:0]     cmp_sum;
   logic                 csr_center_we, csr_radius_we;

   assign csr_center_we = csr_valid && (csr_index == CSR_CENTER);
   assign csr_radius_we = csr_valid && (csr_index == CSR_RADIUS);

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= CENTER_RESET;
         radius_ff <= RADIUS_RESET;
         walk_x_ff <= CENTER_RESET;
         walk_y_ff <= CENTER_RESET;
         done_ff   <= 1'b0;
      end else begin
         if (csr_center_we) begin
            center_ff <= csr_wdata;
         end
         if (csr_radius_we) begin
            radius_ff <= csr_wdata[RADIUS_W-1:0];
         end
         walk_x_ff <= walk_x_in;
         walk_y_ff <= walk_y_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      r2_ff <= radius_ff * radius_ff;
      if (cmd.capture) begin
         dir_ff <= req_direction;
      end
   end

   // neighbour columns, valid while the walker sits still
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         col_ext[j] = offset_coord(walk_x_ff, 2'(j));
         col_ok[j]  = ext_ok(col_ext[j]);
         col_idx[j] = col_ext[j][IDX_W-1:0];
      end
   end

   assign row_ext  = offset_coord(walk_y_ff, cmd.rd_k);
   assign wr_x_ext = offset_coord(walk_x_ff, 2'd1);
   assign wr_y_ext = offset_coord(walk_y_ff, 2'd1);
   assign wr_col   = wr_x_ext[IDX_W-1:0];
   assign wr_row   = wr_y_ext[IDX_W-1:0];

   // sweep after reset, one row per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_row_ff <= '0;
      end else if (cmd.clr_en) begin
         clr_row_ff <= clr_row_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_en) begin
         grid_mem[clr_row_ff] <= '0;
      end else if (wr_en) begin
         grid_mem[wr_row][wr_col] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= grid_mem[row_ext[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_k_ff   <= cmd.rd_k;
         row_ok_ff <= ext_ok(row_ext);
      end
      if (rd_pend_ff) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               if (rd_k_ff == 2'(i)) begin
                  bits_ff[3*i+j] <= row_ok_ff & col_ok[j] & rd_data_ff[col_idx[j]];
               end
            end
         end
      end
   end

   // squared offsets from the center: three for x, three for y
   always_comb begin
      sq_is_x  = (cmd.sq_idx < 3'd3);
      sq_off   = sq_is_x ? cmd.sq_idx[1:0] : 2'(cmd.sq_idx - 3'd3);
      sq_coord = sq_is_x ? walk_x_ff : walk_y_ff;
      sq_ext   = offset_coord(sq_coord, sq_off);
      sq_diff  = {sq_ext[EXT_W-1], sq_ext} - {3'b000, center_ff};
      sq_abs   = sq_diff[EXT_W] ? (~sq_diff + (EXT_W+1)'(1)) : sq_diff;
      sq_prod  = mag_ff * mag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_vld_ff <= 1'b0;
      end else begin
         mag_vld_ff <= cmd.sq_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sq_en) begin
         mag_ff     <= sq_abs[MAG_W-1:0];
         mag_idx_ff <= cmd.sq_idx;
      end
      if (mag_vld_ff) begin
         if (mag_idx_ff < 3'd3) begin
            sqx_ff[mag_idx_ff[1:0]] <= sq_prod[SQ_W-1:0];
         end else begin
            sqy_ff[2'(mag_idx_ff - 3'd3)] <= sq_prod[SQ_W-1:0];
         end
      end
   end

   assign cmp_pos = nb_pos(cmd.cmp_idx);
   assign cmp_sum = {1'b0, sqx_ff[cmp_pos.col]} + {1'b0, sqy_ff[cmp_pos.row]};

   always_ff @(posedge clock) begin
      if (cmd.cmp_en) begin
         circ_ff[cmd.cmp_idx] <= (cmp_sum >= SUM_W'(r2_ff));
      end
   end

   // stick decision and walker update
   assign touch      = |((circ_ff | bits_ff) & NB_MASK);
   assign off_center = (walk_x_ff != center_ff) || (walk_y_ff != center_ff);
   assign delta      = step_delta(dir_ff);
   assign stick_off  = cmd.decide_en && !done_ff && touch && off_center;
   assign wr_en      = stick_off && ext_ok(wr_x_ext) && ext_ok(wr_y_ext);

   always_comb begin
      walk_x_in        = walk_x_ff;
      walk_y_in        = walk_y_ff;
      done_in          = done_ff;
      rsp_x_in         = walk_x_ff;
      rsp_y_in         = walk_y_ff;
      rsp_deposited_in = 1'b0;
      if (csr_center_we) begin
         walk_x_in = csr_wdata;
         walk_y_in = csr_wdata;
      end else if (cmd.decide_en && !done_ff) begin
         if (!touch) begin
            walk_x_in = walk_x_ff + {{(COORD_W-2){delta.dx[1]}}, delta.dx};
            walk_y_in = walk_y_ff + {{(COORD_W-2){delta.dy[1]}}, delta.dy};
            rsp_x_in  = walk_x_in;
            rsp_y_in  = walk_y_in;
         end else if (off_center) begin
            rsp_deposited_in = 1'b1;
            walk_x_in        = center_ff;
            walk_y_in        = center_ff;
         end else begin
            done_in = 1'b1;
         end
      end
   end

   always_comb begin
      if (cmd.decide_en) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide_en) begin
         rsp_x_ff         <= rsp_x_in;
         rsp_y_ff         <= rsp_y_in;
         rsp_deposited_ff <= rsp_deposited_in;
         rsp_finished_ff  <= done_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_walker_x    = rsp_x_ff;
   assign rsp_walker_y    = rsp_y_ff;
   assign rsp_deposited   = rsp_deposited_ff;
   assign rsp_finished    = rsp_finished_ff;

   assign status.clr_last = (clr_row_ff == IDX_W'(GRID_SIDE - 1));
   assign status.done     = done_ff;
   assign status.out_busy = rsp_valid_ff && rsp_stall;

   a_deposit_recenters: assert property (@(posedge clock) disable iff (reset)
      stick_off |=> (walk_x_ff == center_ff) && (walk_y_ff == center_ff) &&
                    rsp_valid_ff && rsp_deposited_ff && !rsp_finished_ff)
      else $error("walker not sent home after a deposit");

   a_done_sticks: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> done_ff)
      else $error("finished flag dropped");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.decide_en |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");

   a_clear_no_deposit: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_en |-> !wr_en && !cmd.rd_en)
      else $error("grid access during clearing sweep");

endmodule
